/* rtl/iol_pkg.sv */
// types and constants shared by the indexed ordered list block
package iol_pkg;

   localparam logic [1:0] OP_HEAD   = 2'd0;
   localparam logic [1:0] OP_TAIL   = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int IO_W     = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   typedef struct packed {
      logic             ins_head;
      logic             ins_tail;
      logic             remove;
      logic [POS_W-1:0] pos;
   } iol_cmd_type;

endpackage

/* rtl/iol_if.sv */
// request and response channel interfaces of the indexed ordered list
interface iol_req_if;
   logic                                valid;
   logic                                ready;
   logic        [iol_pkg::OP_W-1:0]     op;
   logic signed [iol_pkg::IO_W-1:0]     data_in;
   logic        [iol_pkg::POS_W-1:0]    position;

   modport source (output valid, output op, output data_in, output position, input ready);
   modport sink   (input valid, input op, input data_in, input position, output ready);
endinterface

interface iol_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [iol_pkg::IO_W-1:0]     data_out;
   logic        [iol_pkg::STATUS_W-1:0] status;
   logic        [iol_pkg::LEN_W-1:0]    length;

   modport source (output valid, output data_out, output status, output length, input ready);
   modport sink   (input valid, input data_out, input status, input length, output ready);
endinterface

/* rtl/iol_cell.sv */
// one list cell: holds one entry and shifts toward or away from its neighbours
module iol_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
) (
   input  logic                      clock,
   input  iol_pkg::iol_cmd_type      cmd,
   input  logic [CNT_W-1:0]          count,
   input  logic [DATA_WIDTH-1:0]     ins_data,
   input  logic [DATA_WIDTH-1:0]     prev_data,
   input  logic [DATA_WIDTH-1:0]     next_data,
   output logic [DATA_WIDTH-1:0]     value,
   output logic [DATA_WIDTH-1:0]     rd_word
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  at_pos;
   logic                  at_tail;
   logic                  past_pos;

   assign at_pos   = 32'(cmd.pos) == 32'(INDEX);
   assign past_pos = 32'(INDEX) >= 32'(cmd.pos);
   assign at_tail  = 32'(count) == 32'(INDEX);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins_head) begin
         value_in = prev_data;
      end else if (cmd.ins_tail && at_tail) begin
         value_in = ins_data;
      end else if (cmd.remove && past_pos) begin
         value_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value   = value_ff;
   assign rd_word = at_pos ? value_ff : '0;

endmodule

/* rtl/iol_ctrl.sv */
// list control: decode, entry count, status and the response register
module iol_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   iol_req_if.sink                req,
   iol_rsp_if.source              rsp,
   output iol_pkg::iol_cmd_type   cmd,
   output logic [CNT_W-1:0]       count,
   output logic [DATA_WIDTH-1:0]  ins_data,
   input  logic [DATA_WIDTH-1:0]  rd_word [CAPACITY]
);

   logic [CNT_W-1:0]                 count_ff;
   logic [CNT_W-1:0]                 count_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic signed [iol_pkg::IO_W-1:0]  data_out_ff;
   logic signed [iol_pkg::IO_W-1:0]  data_out_in;
   logic [iol_pkg::STATUS_W-1:0]     status_ff;
   logic [iol_pkg::STATUS_W-1:0]     status_in;
   logic [iol_pkg::LEN_W-1:0]        length_ff;
   logic                             fire;
   logic                             full;
   logic                             pos_ok;
   logic [DATA_WIDTH-1:0]            rd_sel;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign pos_ok    = 32'(req.position) < 32'(count_ff);
   assign ins_data  = DATA_WIDTH'(req.data_in);
   assign count     = count_ff;

   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_sel = rd_sel | rd_word[i];
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.pos      = req.position;
      count_in     = count_ff;
      status_in    = iol_pkg::ST_OK;
      data_out_in  = '0;
      unique case (req.op)
         iol_pkg::OP_HEAD, iol_pkg::OP_TAIL: begin
            if (full) begin
               status_in = iol_pkg::ST_FULL;
            end else begin
               cmd.ins_head = fire && (req.op == iol_pkg::OP_HEAD);
               cmd.ins_tail = fire && (req.op == iol_pkg::OP_TAIL);
               count_in     = count_ff + CNT_W'(1);
            end
         end
         iol_pkg::OP_GET: begin
            if (pos_ok) begin
               data_out_in = iol_pkg::IO_W'(signed'(rd_sel));
            end else begin
               status_in   = iol_pkg::ST_RANGE;
               data_out_in = -32'sd1;
            end
         end
         iol_pkg::OP_REMOVE: begin
            if (pos_ok) begin
               cmd.remove = fire;
               count_in   = count_ff - CNT_W'(1);
            end else begin
               status_in = iol_pkg::ST_RANGE;
            end
         end
         default: begin
            status_in = iol_pkg::ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_out_ff <= data_out_in;
         status_ff   <= status_in;
         length_ff   <= iol_pkg::LEN_W'(count_in);
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = data_out_ff;
   assign rsp.status   = status_ff;
   assign rsp.length   = length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("entry count moved without an item");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted item gave no response");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      fire && full && (req.op == iol_pkg::OP_HEAD || req.op == iol_pkg::OP_TAIL)
      |=> $stable(count_ff) && status_ff == iol_pkg::ST_FULL)
      else $error("insert into a full list changed it");

endmodule

/* rtl/indexed_ordered_list_top.sv */
// top level of the indexed ordered list: control plus a chain of entry cells
//
//  channel   dir  handshake           payload
//  req_chan  in   valid / ready       op, data_in, position
//  rsp_chan  out  valid / ready       data_out, status, length
//
//  every operation acts on all cells in parallel
//  one item per cycle while no response is stalled; the response register is written the edge the item is taken
//  a read is a one-hot select across the cells into that register
//  reset clears the entry count and the response valid; cell contents are left as they are
//  a stalled response holds req_chan.ready low only while rsp_chan.ready is low
module indexed_ordered_list_top #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   iol_req_if.sink    req_chan,
   iol_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   iol_pkg::iol_cmd_type   cmd;
   logic [CNT_W-1:0]       count;
   logic [DATA_WIDTH-1:0]  ins_data;
   logic [DATA_WIDTH-1:0]  cell_value [CAPACITY];
   logic [DATA_WIDTH-1:0]  rd_word    [CAPACITY];

   iol_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .rsp      (rsp_chan),
      .cmd      (cmd),
      .count    (count),
      .ins_data (ins_data),
      .rd_word  (rd_word)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_data;
      logic [DATA_WIDTH-1:0] next_data;

      if (i == 0) begin : g_first
         assign prev_data = ins_data;
      end else begin : g_mid
         assign prev_data = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_data = cell_value[i];
      end else begin : g_inner
         assign next_data = cell_value[i+1];
      end

      iol_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count),
         .ins_data  (ins_data),
         .prev_data (prev_data),
         .next_data (next_data),
         .value     (cell_value[i]),
         .rd_word   (rd_word[i])
      );
   end

endmodule
